FILE: rtl/multi_cpu_srtf_scheduler_macros.svh
// assertion macros for the scheduler
`ifndef MULTI_CPU_SRTF_SCHEDULER_MACROS_SVH
`define MULTI_CPU_SRTF_SCHEDULER_MACROS_SVH

// same-cycle implication
`define MCS_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCS_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Constants, codes and record types of the multi-CPU SRTF scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

    localparam int MAX_CPUS    = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int PAR_SLOTS   = 8;

    localparam int CPU_W   = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CNT_W   = $clog2(MAX_CPUS + 1);
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W  = (PAR_SLOTS > 1) ? $clog2(PAR_SLOTS) : 1;
    localparam int ADDR_W  = CPU_W + IDX_W;
    localparam int ENTRIES = MAX_CPUS * QUEUE_DEPTH;

    localparam int PID_W   = 16;
    localparam int EXE_W   = 16;
    localparam int REM_W   = 17;
    localparam int TIME_W  = 32;
    localparam int LOAD_W  = 24;
    localparam int SUB_W   = 2;
    localparam int KIND_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CFGD_W  = 3;

    localparam logic [KIND_W-1:0] KIND_RUNNING  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FINISHED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic REG_CPU_COUNT  = 1'b0;
    localparam logic REG_SPLIT_MODE = 1'b1;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] arr;
        logic [SUB_W-1:0]  sub;
        logic              par;
    } entry_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CIDX_W-1:0] cpu_index;
        logic [PID_W-1:0]  task_pid;
        logic [SUB_W-1:0]  sub_index;
        logic              task_parallel;
        logic [REM_W-1:0]  remaining_time;
        logic [TIME_W-1:0] event_time;
        logic [PID_W-1:0]  procs_remaining;
        logic [TIME_W-1:0] turnaround;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/multi_cpu_srtf_scheduler.sv
// ----------------------------------------------------------------------------
// multi_cpu_srtf_scheduler
// Per-CPU run queues sorted by remaining time, held in one task memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall  operation pid exe_time is_parallel
//  out       source     out_valid/out_stall  kind .. last (ten fields)
//  cfg       sink       cfg_valid/cfg_ready  cfg_index cfg_data
//
//  arrival: ranking, then for a parallel task the subtask length divider, then
//  per subtask a sorted insertion through the memory port, moving entries up.
//  tick: per CPU a head read, shifting the entries behind it on removal, then
//  the finished results, then a running pass with a result per changed head.
//  reset clears counts, loads and the parallel table; memory needs no clear.
//  out_stall only holds the sequencer when a new result or the final flush
//  finds both the output register and the pending register full.
`default_nettype none

module multi_cpu_srtf_scheduler (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           operation,
    input  wire logic [mcs_pkg::PID_W-1:0]      pid,
    input  wire logic [mcs_pkg::EXE_W-1:0]      exe_time,
    input  wire logic                           is_parallel,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [mcs_pkg::KIND_W-1:0]          kind,
    output logic [mcs_pkg::CIDX_W-1:0]          cpu_index,
    output logic [mcs_pkg::PID_W-1:0]           task_pid,
    output logic [mcs_pkg::SUB_W-1:0]           sub_index,
    output logic                                task_parallel,
    output logic [mcs_pkg::REM_W-1:0]           remaining_time,
    output logic [mcs_pkg::TIME_W-1:0]          event_time,
    output logic [mcs_pkg::PID_W-1:0]           procs_remaining,
    output logic [mcs_pkg::TIME_W-1:0]          turnaround,
    output logic                                last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_index,
    input  wire logic [mcs_pkg::CFGD_W-1:0]     cfg_data
);

`include "multi_cpu_srtf_scheduler_macros.svh"

    localparam int CPU_W  = mcs_pkg::CPU_W;
    localparam int CNT_W  = mcs_pkg::CNT_W;
    localparam int IDX_W  = mcs_pkg::IDX_W;
    localparam int QCNT_W = mcs_pkg::QCNT_W;
    localparam int SLOT_W = mcs_pkg::SLOT_W;
    localparam int ADDR_W = mcs_pkg::ADDR_W;
    localparam int NCPU   = mcs_pkg::MAX_CPUS;
    localparam int NSLOT  = mcs_pkg::PAR_SLOTS;
    localparam int REM_W  = mcs_pkg::REM_W;
    localparam int PID_W  = mcs_pkg::PID_W;
    localparam int TIME_W = mcs_pkg::TIME_W;
    localparam int LOAD_W = mcs_pkg::LOAD_W;
    localparam int DIV_CW = $clog2(REM_W);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_A_RANK     = 4'd1;
    localparam logic [3:0] ST_A_DIV      = 4'd2;
    localparam logic [3:0] ST_A_CHECK    = 4'd3;
    localparam logic [3:0] ST_INS_START  = 4'd4;
    localparam logic [3:0] ST_INS_CMP    = 4'd5;
    localparam logic [3:0] ST_INS_WR0    = 4'd6;
    localparam logic [3:0] ST_INS_DONE   = 4'd7;
    localparam logic [3:0] ST_RM_START   = 4'd8;
    localparam logic [3:0] ST_RM_HEAD    = 4'd9;
    localparam logic [3:0] ST_SHIFT      = 4'd10;
    localparam logic [3:0] ST_FIN_OUT    = 4'd11;
    localparam logic [3:0] ST_RUN_START  = 4'd12;
    localparam logic [3:0] ST_RUN_HEAD   = 4'd13;
    localparam logic [3:0] ST_FLUSH      = 4'd14;

    // task memory
    mcs_pkg::entry_t qmem [mcs_pkg::ENTRIES];
    mcs_pkg::entry_t mem_rdata;
    mcs_pkg::entry_t mem_wdata;
    logic              mem_re, mem_we;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            qmem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= qmem[mem_raddr];
        end
    end

    // registers
    logic [3:0]          state_reg, state_next;
    logic [2:0]          cpu_count_reg, cpu_count_next;
    logic                split_reg, split_next;
    logic [QCNT_W-1:0]   count_reg [NCPU];
    logic [QCNT_W-1:0]   count_next [NCPU];
    logic [LOAD_W-1:0]   load_reg [NCPU];
    logic [LOAD_W-1:0]   load_next [NCPU];
    logic                lrv_reg [NCPU];
    logic                lrv_next [NCPU];
    logic [PID_W-1:0]    lrp_reg [NCPU];
    logic [PID_W-1:0]    lrp_next [NCPU];
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [PID_W-1:0]    arrived_reg, arrived_next;
    logic [PID_W-1:0]    finished_reg, finished_next;
    logic                ptv_reg [NSLOT];
    logic                ptv_next [NSLOT];
    logic [CNT_W-1:0]    ptl_reg [NSLOT];
    logic [CNT_W-1:0]    ptl_next [NSLOT];
    logic [PID_W-1:0]    ptp_reg [NSLOT];
    logic [PID_W-1:0]    ptp_next [NSLOT];
    logic [PID_W-1:0]    a_pid_reg, a_pid_next;
    logic [mcs_pkg::EXE_W-1:0] a_exe_reg, a_exe_next;
    logic                a_par_reg, a_par_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    rank_reg [NCPU];
    logic [CNT_W-1:0]    rank_next [NCPU];
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                slot_ok_reg, slot_ok_next;
    logic [CNT_W-1:0]    div_r_reg, div_r_next;
    logic [REM_W-1:0]    div_q_reg, div_q_next;
    logic [DIV_CW-1:0]   div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]    ins_i_reg, ins_i_next;
    logic [CPU_W-1:0]    ins_cpu_reg, ins_cpu_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    cpu_i_reg, cpu_i_next;
    logic [IDX_W-1:0]    sh_last_reg, sh_last_next;
    logic [CNT_W-1:0]    nf_reg, nf_next;
    logic [CNT_W-1:0]    fo_reg, fo_next;
    logic [PID_W-1:0]    fpid_reg [NCPU];
    logic [PID_W-1:0]    fpid_next [NCPU];
    logic                fpar_reg [NCPU];
    logic                fpar_next [NCPU];
    logic [TIME_W-1:0]   ftat_reg [NCPU];
    logic [TIME_W-1:0]   ftat_next [NCPU];
    logic                pend_valid_reg, pend_valid_next;
    mcs_pkg::result_t    pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    mcs_pkg::result_t    out_reg, out_next;

    // derived values
    logic [CNT_W-1:0]    cc;
    logic [CNT_W-1:0]    rank_w [NCPU];
    logic [SLOT_W-1:0]   free_slot;
    logic                free_ok;
    logic [SLOT_W-1:0]   match_slot;
    logic                match_ok;
    logic [CPU_W-1:0]    sel_cpu;
    logic                full_hit;
    logic [CNT_W-1:0]    k_w;
    logic [CPU_W-1:0]    cur_cpu;
    logic                out_free, can_emit;

    always_comb
    begin
        if (cpu_count_reg == 3'd0)
        begin
            cc = CNT_W'(1);
        end
        else if (32'(cpu_count_reg) > NCPU)
        begin
            cc = CNT_W'(NCPU);
        end
        else
        begin
            cc = CNT_W'(cpu_count_reg);
        end
    end

    // stable load ranking of the CPUs in use
    always_comb
    begin
        for (int c = 0; c < NCPU; c++)
        begin
            rank_w[c] = '0;
            for (int j = 0; j < NCPU; j++)
            begin
                if (CNT_W'(j) < cc && (load_reg[j] < load_reg[c] ||
                    (load_reg[j] == load_reg[c] && j < c)))
                begin
                    rank_w[c] = CNT_W'(rank_w[c] + 1'b1);
                end
            end
        end
    end

    always_comb
    begin
        free_slot  = '0;
        free_ok    = 1'b0;
        match_slot = '0;
        match_ok   = 1'b0;
        for (int s = 0; s < NSLOT; s++)
        begin
            if (!free_ok && !ptv_reg[s])
            begin
                free_slot = SLOT_W'(s);
                free_ok   = 1'b1;
            end
            if (!match_ok && ptv_reg[s] && ptp_reg[s] == mem_rdata.pid)
            begin
                match_slot = SLOT_W'(s);
                match_ok   = 1'b1;
            end
        end
    end

    always_comb
    begin
        sel_cpu  = '0;
        full_hit = 1'b0;
        for (int c = 0; c < NCPU; c++)
        begin
            if (CNT_W'(c) < cc && rank_reg[c] == ins_i_reg)
            begin
                sel_cpu = CPU_W'(c);
            end
            if (CNT_W'(c) < cc && rank_reg[c] < k_reg &&
                32'(count_reg[c]) >= mcs_pkg::QUEUE_DEPTH)
            begin
                full_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (!a_par_reg)
        begin
            k_w = CNT_W'(1);
        end
        else if (split_reg)
        begin
            k_w = cc;
        end
        else if (a_exe_reg < mcs_pkg::EXE_W'(cc))
        begin
            k_w = CNT_W'(a_exe_reg);
        end
        else
        begin
            k_w = cc;
        end
        if (k_w == '0)
        begin
            k_w = CNT_W'(1);
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_INS_START:
            begin
                cur_cpu = sel_cpu;
            end
            ST_INS_CMP, ST_INS_WR0, ST_INS_DONE:
            begin
                cur_cpu = ins_cpu_reg;
            end
            default:
            begin
                cur_cpu = cpu_i_reg[CPU_W-1:0];
            end
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign can_emit = !pend_valid_reg || out_free;

    always_comb
    begin
        mcs_pkg::entry_t   nw;
        mcs_pkg::entry_t   e;
        mcs_pkg::result_t  res;
        logic              emit;
        logic [REM_W+PID_W-1:0] new_key;
        logic [REM_W+PID_W-1:0] old_key;
        logic [REM_W-1:0]  dividend;
        logic [CNT_W:0]    trial;
        logic              qbit;
        logic              done;
        logic              changed;
        logic [CNT_W-1:0]  left;
        logic [QCNT_W-1:0] cnt;

        state_next      = state_reg;
        cpu_count_next  = cpu_count_reg;
        split_next      = split_reg;
        count_next      = count_reg;
        load_next       = load_reg;
        lrv_next        = lrv_reg;
        lrp_next        = lrp_reg;
        time_next       = time_reg;
        arrived_next    = arrived_reg;
        finished_next   = finished_reg;
        ptv_next        = ptv_reg;
        ptl_next        = ptl_reg;
        ptp_next        = ptp_reg;
        a_pid_next      = a_pid_reg;
        a_exe_next      = a_exe_reg;
        a_par_next      = a_par_reg;
        k_next          = k_reg;
        rem_next        = rem_reg;
        rank_next       = rank_reg;
        slot_next       = slot_reg;
        slot_ok_next    = slot_ok_reg;
        div_r_next      = div_r_reg;
        div_q_next      = div_q_reg;
        div_cnt_next    = div_cnt_reg;
        ins_i_next      = ins_i_reg;
        ins_cpu_next    = ins_cpu_reg;
        j_next          = j_reg;
        cpu_i_next      = cpu_i_reg;
        sh_last_next    = sh_last_reg;
        nf_next         = nf_reg;
        fo_next         = fo_reg;
        fpid_next       = fpid_reg;
        fpar_next       = fpar_reg;
        ftat_next       = ftat_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;

        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = '0;
        mem_waddr = '0;
        mem_wdata = '0;

        nw.rem  = rem_reg;
        nw.pid  = a_pid_reg;
        nw.arr  = time_reg;
        nw.sub  = mcs_pkg::SUB_W'(ins_i_reg);
        nw.par  = a_par_reg;
        e       = mem_rdata;
        new_key = {rem_reg, a_pid_reg};
        old_key = {e.rem, e.pid};
        cnt     = count_reg[cur_cpu];

        emit = 1'b0;
        res  = '0;
        res.event_time      = time_reg;
        res.procs_remaining = PID_W'(arrived_reg - finished_reg);

        dividend = REM_W'({1'b0, a_exe_reg} + REM_W'(k_w) - REM_W'(1));
        trial    = {div_r_reg, div_q_reg[REM_W-1]};
        qbit     = (trial >= {1'b0, k_reg});
        done     = 1'b1;
        changed  = !(lrv_reg[cur_cpu] && lrp_reg[cur_cpu] == e.pid);
        left     = ptl_reg[match_slot];

        if (cfg_valid)
        begin
            unique case (cfg_index)
                mcs_pkg::REG_CPU_COUNT:
                begin
                    cpu_count_next = cfg_data;
                end
                mcs_pkg::REG_SPLIT_MODE:
                begin
                    split_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == mcs_pkg::OP_TICK)
                    begin
                        cpu_i_next = '0;
                        nf_next    = '0;
                        state_next = ST_RM_START;
                    end
                    else
                    begin
                        a_pid_next = pid;
                        a_exe_next = exe_time;
                        a_par_next = is_parallel;
                        state_next = ST_A_RANK;
                    end
                end
            end
            ST_A_RANK:
            begin
                rank_next    = rank_w;
                slot_next    = free_slot;
                slot_ok_next = free_ok;
                k_next       = k_w;
                if (a_par_reg)
                begin
                    div_q_next   = dividend;
                    div_r_next   = '0;
                    div_cnt_next = '0;
                    state_next   = ST_A_DIV;
                end
                else
                begin
                    rem_next   = {1'b0, a_exe_reg};
                    state_next = ST_A_CHECK;
                end
            end
            ST_A_DIV:
            begin
                div_r_next   = qbit ? CNT_W'(trial - {1'b0, k_reg}) : CNT_W'(trial);
                div_q_next   = {div_q_reg[REM_W-2:0], qbit};
                div_cnt_next = DIV_CW'(div_cnt_reg + 1'b1);
                if (32'(div_cnt_reg) == REM_W - 1)
                begin
                    rem_next   = REM_W'({div_q_reg[REM_W-2:0], qbit} + REM_W'(1));
                    state_next = ST_A_CHECK;
                end
            end
            ST_A_CHECK:
            begin
                if ((a_par_reg && !slot_ok_reg) || full_hit)
                begin
                    if (can_emit)
                    begin
                        emit              = 1'b1;
                        res.kind          = mcs_pkg::KIND_REJECTED;
                        res.task_pid      = a_pid_reg;
                        res.task_parallel = a_par_reg;
                        state_next        = ST_FLUSH;
                    end
                end
                else
                begin
                    if (a_par_reg)
                    begin
                        ptv_next[slot_reg] = 1'b1;
                        ptl_next[slot_reg] = k_reg;
                        ptp_next[slot_reg] = a_pid_reg;
                    end
                    ins_i_next = '0;
                    state_next = ST_INS_START;
                end
            end
            ST_INS_START:
            begin
                ins_cpu_next = sel_cpu;
                if (cnt == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = {sel_cpu, IDX_W'(0)};
                    mem_wdata  = nw;
                    state_next = ST_INS_DONE;
                end
                else
                begin
                    j_next     = IDX_W'(cnt - QCNT_W'(1));
                    mem_re     = 1'b1;
                    mem_raddr  = {sel_cpu, IDX_W'(cnt - QCNT_W'(1))};
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                // walk down from the tail, moving larger entries up by one
                mem_we = 1'b1;
                if (j_reg != '0)
                begin
                    mem_waddr = {ins_cpu_reg, IDX_W'(j_reg + 1'b1)};
                    if (old_key >= new_key)
                    begin
                        mem_wdata = e;
                        mem_re    = 1'b1;
                        mem_raddr = {ins_cpu_reg, IDX_W'(j_reg - 1'b1)};
                        j_next    = IDX_W'(j_reg - 1'b1);
                    end
                    else
                    begin
                        mem_wdata  = nw;
                        state_next = ST_INS_DONE;
                    end
                end
                else
                begin
                    mem_waddr = {ins_cpu_reg, IDX_W'(1)};
                    if (old_key > new_key)
                    begin
                        mem_wdata  = e;
                        state_next = ST_INS_WR0;
                    end
                    else
                    begin
                        mem_wdata  = nw;
                        state_next = ST_INS_DONE;
                    end
                end
            end
            ST_INS_WR0:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {ins_cpu_reg, IDX_W'(0)};
                mem_wdata  = nw;
                state_next = ST_INS_DONE;
            end
            ST_INS_DONE:
            begin
                count_next[ins_cpu_reg] = QCNT_W'(cnt + 1'b1);
                load_next[ins_cpu_reg]  = LOAD_W'(load_reg[ins_cpu_reg] + LOAD_W'(rem_reg));
                if (CNT_W'(ins_i_reg + 1'b1) == k_reg)
                begin
                    arrived_next = PID_W'(arrived_reg + 1'b1);
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ins_i_next = CNT_W'(ins_i_reg + 1'b1);
                    state_next = ST_INS_START;
                end
            end
            ST_RM_START:
            begin
                if (cpu_i_reg >= cc)
                begin
                    finished_next = PID_W'(finished_reg + PID_W'(nf_reg));
                    fo_next       = '0;
                    state_next    = ST_FIN_OUT;
                end
                else if (cnt == '0)
                begin
                    cpu_i_next = CNT_W'(cpu_i_reg + 1'b1);
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {cur_cpu, IDX_W'(0)};
                    state_next = ST_RM_HEAD;
                end
            end
            ST_RM_HEAD:
            begin
                if (e.rem != '0)
                begin
                    cpu_i_next = CNT_W'(cpu_i_reg + 1'b1);
                    state_next = ST_RM_START;
                end
                else
                begin
                    if (e.par && match_ok)
                    begin
                        if (left != '0)
                        begin
                            left = CNT_W'(left - 1'b1);
                        end
                        if (left == '0)
                        begin
                            ptv_next[match_slot] = 1'b0;
                        end
                        else
                        begin
                            ptl_next[match_slot] = left;
                            done = 1'b0;
                        end
                    end
                    if (done)
                    begin
                        fpid_next[nf_reg[CPU_W-1:0]] = e.pid;
                        fpar_next[nf_reg[CPU_W-1:0]] = e.par;
                        ftat_next[nf_reg[CPU_W-1:0]] = TIME_W'(time_reg - e.arr);
                        nf_next = CNT_W'(nf_reg + 1'b1);
                    end
                    count_next[cur_cpu] = QCNT_W'(cnt - 1'b1);
                    sh_last_next        = IDX_W'(cnt - 1'b1);
                    if (cnt > QCNT_W'(1))
                    begin
                        j_next     = IDX_W'(1);
                        mem_re     = 1'b1;
                        mem_raddr  = {cur_cpu, IDX_W'(1)};
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        cpu_i_next = CNT_W'(cpu_i_reg + 1'b1);
                        state_next = ST_RM_START;
                    end
                end
            end
            ST_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = {cur_cpu, IDX_W'(j_reg - 1'b1)};
                mem_wdata = e;
                if (j_reg < sh_last_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {cur_cpu, IDX_W'(j_reg + 1'b1)};
                    j_next    = IDX_W'(j_reg + 1'b1);
                end
                else
                begin
                    cpu_i_next = CNT_W'(cpu_i_reg + 1'b1);
                    state_next = ST_RM_START;
                end
            end
            ST_FIN_OUT:
            begin
                if (fo_reg < nf_reg)
                begin
                    if (can_emit)
                    begin
                        emit              = 1'b1;
                        res.kind          = mcs_pkg::KIND_FINISHED;
                        res.task_pid      = fpid_reg[fo_reg[CPU_W-1:0]];
                        res.task_parallel = fpar_reg[fo_reg[CPU_W-1:0]];
                        res.turnaround    = ftat_reg[fo_reg[CPU_W-1:0]];
                        fo_next           = CNT_W'(fo_reg + 1'b1);
                    end
                end
                else
                begin
                    cpu_i_next = '0;
                    state_next = ST_RUN_START;
                end
            end
            ST_RUN_START:
            begin
                if (cpu_i_reg >= cc)
                begin
                    time_next  = TIME_W'(time_reg + 1'b1);
                    state_next = ST_FLUSH;
                end
                else if (cnt == '0)
                begin
                    cpu_i_next = CNT_W'(cpu_i_reg + 1'b1);
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {cur_cpu, IDX_W'(0)};
                    state_next = ST_RUN_HEAD;
                end
            end
            ST_RUN_HEAD:
            begin
                // read data holds while waiting for a result slot
                if (!changed || can_emit)
                begin
                    if (changed)
                    begin
                        emit               = 1'b1;
                        res.kind           = mcs_pkg::KIND_RUNNING;
                        res.cpu_index      = mcs_pkg::CIDX_W'(cur_cpu);
                        res.task_pid       = e.pid;
                        res.sub_index      = e.par ? e.sub : '0;
                        res.task_parallel  = e.par;
                        res.remaining_time = e.rem;
                        lrv_next[cur_cpu]  = 1'b1;
                        lrp_next[cur_cpu]  = e.pid;
                    end
                    if (e.rem != '0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = {cur_cpu, IDX_W'(0)};
                        mem_wdata = e;
                        mem_wdata.rem = REM_W'(e.rem - 1'b1);
                        if (load_reg[cur_cpu] != '0)
                        begin
                            load_next[cur_cpu] = LOAD_W'(load_reg[cur_cpu] - 1'b1);
                        end
                    end
                    cpu_i_next = CNT_W'(cpu_i_reg + 1'b1);
                    state_next = ST_RUN_START;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // one word of look-ahead so the final word can carry last
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = res;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cpu_count_reg  <= 3'd1;
            split_reg      <= 1'b0;
            time_reg       <= '0;
            arrived_reg    <= '0;
            finished_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < NCPU; c++)
            begin
                count_reg[c] <= '0;
                load_reg[c]  <= '0;
                lrv_reg[c]   <= 1'b0;
            end
            for (int s = 0; s < NSLOT; s++)
            begin
                ptv_reg[s] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cpu_count_reg  <= cpu_count_next;
            split_reg      <= split_next;
            time_reg       <= time_next;
            arrived_reg    <= arrived_next;
            finished_reg   <= finished_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            count_reg      <= count_next;
            load_reg       <= load_next;
            lrv_reg        <= lrv_next;
            ptv_reg        <= ptv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lrp_reg     <= lrp_next;
        ptl_reg     <= ptl_next;
        ptp_reg     <= ptp_next;
        a_pid_reg   <= a_pid_next;
        a_exe_reg   <= a_exe_next;
        a_par_reg   <= a_par_next;
        k_reg       <= k_next;
        rem_reg     <= rem_next;
        rank_reg    <= rank_next;
        slot_reg    <= slot_next;
        slot_ok_reg <= slot_ok_next;
        div_r_reg   <= div_r_next;
        div_q_reg   <= div_q_next;
        div_cnt_reg <= div_cnt_next;
        ins_i_reg   <= ins_i_next;
        ins_cpu_reg <= ins_cpu_next;
        j_reg       <= j_next;
        cpu_i_reg   <= cpu_i_next;
        sh_last_reg <= sh_last_next;
        nf_reg      <= nf_next;
        fo_reg      <= fo_next;
        fpid_reg    <= fpid_next;
        fpar_reg    <= fpar_next;
        ftat_reg    <= ftat_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    assign in_stall        = (state_reg != ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign cpu_index       = out_reg.cpu_index;
    assign task_pid        = out_reg.task_pid;
    assign sub_index       = out_reg.sub_index;
    assign task_parallel   = out_reg.task_parallel;
    assign remaining_time  = out_reg.remaining_time;
    assign event_time      = out_reg.event_time;
    assign procs_remaining = out_reg.procs_remaining;
    assign turnaround      = out_reg.turnaround;
    assign last            = out_reg.last;

    `MCS_ASSERT_IMPLY(a_idle_no_pending, clk, rst_n, state_reg == ST_IDLE, !pend_valid_reg, "pending word left behind at idle")
    `MCS_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_reg != ST_IDLE, "accepted word did not start work")
    `MCS_ASSERT_IMPLY(a_insert_room, clk, rst_n, state_reg == ST_INS_START, 32'(count_reg[sel_cpu]) < mcs_pkg::QUEUE_DEPTH, "insert into a full queue")

endmodule

`default_nettype wire

FILE: verif/tb_multi_cpu_srtf_scheduler.sv
// ----------------------------------------------------------------------------
// tb_multi_cpu_srtf_scheduler
// Self-checking bench for the multi-CPU SRTF scheduler. A built-in scheduler
// model predicts every report for each accepted word. Directed tests cover
// zero and full-range fields, parallel splits and rejections. Random phases
// run under several CPU counts and split modes, with sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multi_cpu_srtf_scheduler;
    import mcs_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic operation;
    logic [PID_W-1:0] pid;
    logic [EXE_W-1:0] exe_time;
    logic is_parallel;
    logic out_valid;
    logic out_stall;
    logic [KIND_W-1:0] kind;
    logic [CIDX_W-1:0] cpu_index;
    logic [PID_W-1:0] task_pid;
    logic [SUB_W-1:0] sub_index;
    logic task_parallel;
    logic [REM_W-1:0] remaining_time;
    logic [TIME_W-1:0] event_time;
    logic [PID_W-1:0] procs_remaining;
    logic [TIME_W-1:0] turnaround;
    logic last;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [CFGD_W-1:0] cfg_data;

    multi_cpu_srtf_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .pid(pid), .exe_time(exe_time),
        .is_parallel(is_parallel),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .cpu_index(cpu_index), .task_pid(task_pid),
        .sub_index(sub_index), .task_parallel(task_parallel),
        .remaining_time(remaining_time), .event_time(event_time),
        .procs_remaining(procs_remaining), .turnaround(turnaround),
        .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // scheduler model state
    entry_t run_q[MAX_CPUS][$];
    int unsigned cpu_load[MAX_CPUS];
    logic [16:0] last_run[MAX_CPUS];
    logic [31:0] now_tick;
    logic [15:0] arrived_cnt;
    logic [15:0] finished_cnt;
    bit pt_valid[PAR_SLOTS];
    int pt_left[PAR_SLOTS];
    logic [15:0] pt_pid[PAR_SLOTS];
    logic [2:0] cur_cpus;
    logic cur_split;

    result_t expected_reports[$];
    int fail_count;
    int idle_cycles;
    bit gaps_on;
    bit stall_on;
    int burst_left;
    int stall_run;
    bit stall_now;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int cpus_used();
        if (cur_cpus == 0) return 1;
        if (cur_cpus > MAX_CPUS) return MAX_CPUS;
        return cur_cpus;
    endfunction

    function automatic logic [32:0] task_key(entry_t e);
        return {e.rem[15:0] + 33'd0, 16'd0} | {e.rem, e.pid};
    endfunction

    task automatic push_report(logic [1:0] k, int cpu, logic [15:0] p, int sub,
                               logic par, int unsigned rem, logic [31:0] tat);
        result_t r;
        r.kind = k;
        r.cpu_index = cpu[1:0];
        r.task_pid = p;
        r.sub_index = sub[1:0];
        r.task_parallel = par;
        r.remaining_time = rem[16:0];
        r.event_time = now_tick;
        r.procs_remaining = arrived_cnt - finished_cnt;
        r.turnaround = tat;
        r.last = 1'b0;
        expected_reports.push_back(r);
    endtask

    task automatic place_task(int c, entry_t ent);
        int n;
        int pos;
        n = run_q[c].size();
        if (n == 0 || {run_q[c][0].rem, run_q[c][0].pid} > {ent.rem, ent.pid}) begin
            pos = 0;
        end
        else begin
            pos = 1;
            while (pos < n && {run_q[c][pos].rem, run_q[c][pos].pid} < {ent.rem, ent.pid})
                pos++;
        end
        run_q[c].insert(pos, ent);
        cpu_load[c] += ent.rem;
    endtask

    task automatic predict_arrival(logic [15:0] p, logic [15:0] e, logic par);
        int cc;
        int order[MAX_CPUS];
        int k;
        int unsigned rem;
        int slot;
        int j;
        int key_cpu;
        bit reject;
        entry_t ent;
        cc = cpus_used();
        slot = -1;
        for (int i = 0; i < cc; i++) order[i] = i;
        for (int i = 1; i < cc; i++) begin
            key_cpu = order[i];
            j = i;
            while (j > 0 && cpu_load[order[j-1]] > cpu_load[key_cpu]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key_cpu;
        end
        if (!par) begin
            k = 1;
            rem = e;
        end
        else begin
            k = cur_split ? cc : ((e < cc) ? int'(e) : cc);
            if (k == 0) k = 1;
            rem = (int'(e) + k - 1) / k + 1;
            for (int s = 0; s < PAR_SLOTS; s++) begin
                if (!pt_valid[s]) begin
                    slot = s;
                    break;
                end
            end
        end
        reject = par && slot < 0;
        for (int i = 0; i < k; i++)
            if (run_q[order[i]].size() >= QUEUE_DEPTH) reject = 1'b1;
        if (reject) begin
            push_report(KIND_REJECTED, 0, p, 0, par, 0, 32'd0);
            expected_reports[expected_reports.size()-1].last = 1'b1;
            return;
        end
        if (par) begin
            pt_valid[slot] = 1'b1;
            pt_left[slot] = k;
            pt_pid[slot] = p;
        end
        for (int i = 0; i < k; i++) begin
            ent.rem = rem[16:0];
            ent.pid = p;
            ent.arr = now_tick;
            ent.sub = i[1:0];
            ent.par = par;
            place_task(order[i], ent);
        end
        arrived_cnt++;
    endtask

    task automatic predict_tick();
        int cc;
        int nf;
        int n;
        int left;
        bit done;
        entry_t h;
        logic [15:0] fpid[MAX_CPUS];
        logic fpar[MAX_CPUS];
        logic [31:0] ftat[MAX_CPUS];
        cc = cpus_used();
        nf = 0;
        n = 0;
        for (int i = 0; i < cc; i++) begin
            if (run_q[i].size() == 0 || run_q[i][0].rem != 0) continue;
            h = run_q[i][0];
            done = 1'b1;
            if (h.par) begin
                for (int s = 0; s < PAR_SLOTS; s++) begin
                    if (pt_valid[s] && pt_pid[s] == h.pid) begin
                        left = pt_left[s];
                        if (left > 0) left--;
                        if (left == 0) pt_valid[s] = 1'b0;
                        else begin
                            pt_left[s] = left;
                            done = 1'b0;
                        end
                        break;
                    end
                end
            end
            if (done) begin
                fpid[nf] = h.pid;
                fpar[nf] = h.par;
                ftat[nf] = now_tick - h.arr;
                nf++;
            end
            void'(run_q[i].pop_front());
        end
        finished_cnt += nf[15:0];
        for (int i = 0; i < nf; i++) begin
            push_report(KIND_FINISHED, 0, fpid[i], 0, fpar[i], 0, ftat[i]);
            n++;
        end
        for (int i = 0; i < cc; i++) begin
            if (run_q[i].size() == 0) continue;
            h = run_q[i][0];
            if (!(last_run[i][16] && last_run[i][15:0] == h.pid)) begin
                push_report(KIND_RUNNING, i, h.pid, h.par ? int'(h.sub) : 0, h.par,
                            h.rem, 32'd0);
                n++;
                last_run[i] = {1'b1, h.pid};
            end
            if (h.rem > 0) begin
                run_q[i][0].rem = h.rem - 1;
                if (cpu_load[i] > 0) cpu_load[i]--;
            end
        end
        now_tick++;
        if (n > 0) expected_reports[expected_reports.size()-1].last = 1'b1;
    endtask

    // drive one word and hold it until accepted
    task automatic send_word(logic op, logic [15:0] p, logic [15:0] e, logic par);
        in_valid <= 1'b1;
        operation <= op;
        pid <= p;
        exe_time <= e;
        is_parallel <= par;
        do @(posedge clk); while (in_stall);
        if (op == OP_TICK) predict_tick();
        else predict_arrival(p, e, par);
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 12);
            if (gaps_on) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic arrive(logic [15:0] p, logic [15:0] e, logic par);
        send_word(OP_ARRIVAL, p, e, par);
    endtask

    task automatic tick();
        send_word(OP_TICK, $urandom, $urandom, $urandom_range(0, 1));
    endtask

    // wait for every report, then let a pending arrival finish its insertion
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CPU_COUNT) cur_cpus = val;
        else cur_split = val[0];
    endtask

    task automatic set_config(logic [2:0] cpus, logic split);
        settle();
        write_reg(REG_CPU_COUNT, cpus);
        write_reg(REG_SPLIT_MODE, split);
    endtask

    task automatic test_basics();
        gaps_on = 1'b0;
        stall_on = 1'b0;
        set_config(3'd4, 1'b0);
        arrive(16'd0, 16'd0, 1'b0);
        arrive(16'd10, 16'd1, 1'b0);
        arrive(16'd11, 16'd0, 1'b1);
        arrive(16'd12, 16'd2, 1'b1);
        arrive(16'd13, 16'd5, 1'b1);
        repeat (4) tick();
        set_config(3'd3, 1'b1);
        arrive(16'd14, 16'd1, 1'b1);
        arrive(16'd15, 16'd7, 1'b1);
        repeat (6) tick();
    endtask

    task automatic test_random();
        logic [2:0] cpus_seq[6] = '{3'd2, 3'd4, 3'd1, 3'd0, 3'd7, 3'd3};
        int len;
        logic [15:0] e;
        logic par;
        for (int ph = 0; ph < 6; ph++) begin
            set_config(cpus_seq[ph], $urandom_range(0, 1));
            gaps_on = ph != 2;
            stall_on = ph != 4;
            for (int seq = 0; seq < 16; seq++) begin
                len = $urandom_range(1, 3);
                for (int a = 0; a < len; a++) begin
                    par = $urandom_range(0, 2) == 0;
                    e = $urandom_range(0, 12);
                    if (!par && $urandom_range(0, 24) == 0) e = $urandom;
                    arrive($urandom, e, par);
                end
                repeat ($urandom_range(1, 5)) tick();
            end
        end
    endtask

    task automatic test_limits();
        gaps_on = 1'b1;
        stall_on = 1'b1;
        set_config(3'd1, 1'b0);
        // one subtask of the longest job: ceil plus one overflows 16 bits
        arrive(16'hFFFF, 16'hFFFF, 1'b1);
        tick();
        set_config(3'd7, 1'b1);
        // parallel table runs out before the queues do
        for (int i = 0; i < PAR_SLOTS + 1; i++) arrive(16'h8000 + i, 16'd60000, 1'b1);
        tick();
        set_config(3'd0, 1'b0);
        // cpu 0 queue overflows
        for (int i = 0; i < QUEUE_DEPTH; i++) arrive(16'h9000 + i, 16'd50000, 1'b0);
        repeat (2) tick();
    endtask

    // receiver stalls in runs of random length
    always @(posedge clk) begin
        if (stall_run == 0) begin
            stall_run = $urandom_range(1, 20);
            stall_now = stall_on && $urandom_range(0, 2) == 0;
        end
        stall_run--;
        out_stall <= stall_now;
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0d got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_reports.size() == 0) begin
                $error("report word with nothing expected, pid %0d", task_pid);
                fail_count++;
            end
            else begin
                e = expected_reports.pop_front();
                check_field("kind", e.kind, kind);
                check_field("cpu_index", e.cpu_index, cpu_index);
                check_field("task_pid", e.task_pid, task_pid);
                check_field("sub_index", e.sub_index, sub_index);
                check_field("task_parallel", e.task_parallel, task_parallel);
                check_field("remaining_time", e.remaining_time, remaining_time);
                check_field("event_time", e.event_time, event_time);
                check_field("procs_remaining", e.procs_remaining, procs_remaining);
                check_field("turnaround", e.turnaround, turnaround);
                check_field("last", e.last, last);
            end
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_ARRIVAL;
        pid = '0;
        exe_time = '0;
        is_parallel = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CPU_COUNT;
        cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        stall_run = 0;
        stall_now = 1'b0;
        gaps_on = 1'b0;
        stall_on = 1'b0;
        for (int i = 0; i < MAX_CPUS; i++) begin
            cpu_load[i] = 0;
            last_run[i] = '0;
        end
        for (int s = 0; s < PAR_SLOTS; s++) begin
            pt_valid[s] = 1'b0;
            pt_left[s] = 0;
            pt_pid[s] = '0;
        end
        now_tick = '0;
        arrived_cnt = '0;
        finished_cnt = '0;
        cur_cpus = 3'd1;
        cur_split = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basics();
        test_random();
        test_limits();
        settle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/mcs_pkg.sv
rtl/multi_cpu_srtf_scheduler.sv
verif/tb_multi_cpu_srtf_scheduler.sv
